FILE: rtl/core/scpf_pkg.sv
// Package for the sync/checksum pixel framer: sizes, beat payload types and
// small position helpers. No dependencies; scpf_if and the framer top in rtl/core use it.
package scpf_pkg;

    localparam int LED_COUNT = 150;
    localparam int PKT       = 3 * LED_COUNT + 3;
    localparam int AW        = $clog2(PKT);
    localparam int PIX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    localparam logic [7:0] SYNC_RESET = 8'hAA;

    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_PULL = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic       frame_ok;
        logic       byte_dropped;
        logic       pixel_valid;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } t_out;

    // Next ring position, wrapping at the window length.
    function automatic logic [AW-1:0] pos_inc(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        if (a == AW'(PKT - 1)) begin
            r = '0;
        end else begin
            r = a + AW'(1);
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/scpf_if.sv
// Valid/ready channel interfaces for the framer's input and result beats.
// Depends on scpf_pkg for the payload types.
interface scpf_in_if;
    logic              valid;
    logic              ready;
    scpf_pkg::t_in     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface scpf_out_if;
    logic              valid;
    logic              ready;
    scpf_pkg::t_out    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/scpf_ram.sv
// Generic single-port RAM with a registered read port.
// No dependencies.
module scpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/sync_checksum_pixel_framer.sv
// Top level of the sync/checksum pixel framer: byte ring in one RAM, running sum,
// frame latch and pixel readout. Depends on scpf_pkg, scpf_if and scpf_ram.
//
//  channel    dir  handshake          payload
//  i_in       in   valid/ready        func, rx_byte
//  o_out      out  valid/ready        frame_ok, byte_dropped, pixel_valid,
//                                     red, green, blue, last_pixel
//  config     in   i_cfg_we only      i_cfg_wdata = sync byte value
//
// A received byte is handled as a ring read of the oldest byte in S_IDLE, then
// the ring write and the check in S_BWR. A pixel pull reads the three color
// bytes out of the single RAM port one a cycle, in S_IDLE, S_P1 and S_P2, and
// forms the result in S_P3. A dropped byte or a pull with no frame latched goes
// to S_HOLD. The ring needs no clearing pass after reset: unwritten entries
// are tracked by the write position and a full flag. The next beat is accepted
// as soon as the sequencer is idle, even while the previous result still waits
// in the output register; a result that finds it occupied waits in S_HOLD.
module sync_checksum_pixel_framer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    scpf_in_if.sink              i_in,
    scpf_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata
);

    localparam int AW    = scpf_pkg::AW;
    localparam int PIX_W = scpf_pkg::PIX_W;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_BWR  = 6'b000010,
        S_P1   = 6'b000100,
        S_P2   = 6'b001000,
        S_P3   = 6'b010000,
        S_HOLD = 6'b100000
    } t_state;

    // Control state.
    t_state             r_state, n_state;
    logic [7:0]         r_sync, n_sync;
    logic [AW-1:0]      r_wpos, n_wpos;
    logic               r_full, n_full;
    logic [15:0]        r_sum, n_sum;
    logic               r_pending, n_pending;
    logic [PIX_W-1:0]   r_pix_pos, n_pix_pos;
    logic [AW-1:0]      r_pix_addr, n_pix_addr;
    logic [7:0]         r_next_old, n_next_old;
    logic [7:0]         r_prev1, n_prev1;
    logic [7:0]         r_prev2, n_prev2;
    logic               r_out_valid, n_out_valid;

    // Payload state.
    logic [7:0]          r_byte, n_byte;
    logic                r_rd_ok, n_rd_ok;
    logic [7:0]          r_red, n_red;
    logic [7:0]          r_green, n_green;
    scpf_pkg::t_out      r_res, n_res;
    scpf_pkg::t_out      r_out, n_out;

    // RAM port.
    logic               mem_en;
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [7:0]         mem_wdata;
    logic [7:0]         mem_rdata;

    // Byte check and readout helpers.
    logic               accept;
    logic               out_free;
    logic [7:0]         rd_byte;
    logic [AW-1:0]      start_pos;
    logic [15:0]        sum_a;
    logic               match;
    logic               last;
    scpf_pkg::t_out     fin;

    scpf_ram #(
        .WIDTH (8),
        .DEPTH (scpf_pkg::PKT)
    ) u_ring (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // An entry never written since reset reads as zero. Before the first wrap
    // the written entries are exactly those below the write position.
    assign rd_byte = r_rd_ok ? mem_rdata : 8'h00;

    // The byte read in the accept cycle is the one just past the write
    // position, which becomes the oldest window byte once the new one lands.
    assign start_pos = scpf_pkg::pos_inc(r_wpos);
    assign sum_a     = r_sum - {8'h00, r_next_old} + {8'h00, r_prev2};
    assign match     = (rd_byte == r_sync) && ({r_prev1, r_byte} == sum_a);
    assign last      = (r_pix_pos == PIX_W'(scpf_pkg::LED_COUNT - 1));

    always_comb begin
        n_state     = r_state;
        n_sync      = i_cfg_we ? i_cfg_wdata : r_sync;
        n_wpos      = r_wpos;
        n_full      = r_full;
        n_sum       = r_sum;
        n_pending   = r_pending;
        n_pix_pos   = r_pix_pos;
        n_pix_addr  = r_pix_addr;
        n_next_old  = r_next_old;
        n_prev1     = r_prev1;
        n_prev2     = r_prev2;
        n_out_valid = r_out_valid;
        n_byte      = r_byte;
        n_rd_ok     = r_rd_ok;
        n_red       = r_red;
        n_green     = r_green;
        n_res       = r_res;
        n_out       = r_out;
        mem_en      = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = r_pix_addr;
        mem_wdata   = r_byte;
        fin         = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_byte = i_in.data.rx_byte;
                    n_res  = '0;
                    if (i_in.data.func == scpf_pkg::FUNC_BYTE) begin
                        if (r_pending) begin
                            // Readout pending: the byte is dropped untouched.
                            n_res.byte_dropped = 1'b1;
                            n_state            = S_HOLD;
                        end else begin
                            mem_en   = 1'b1;
                            mem_addr = start_pos;
                            n_rd_ok  = r_full || (start_pos < r_wpos);
                            n_state  = S_BWR;
                        end
                    end else begin
                        if (r_pending) begin
                            mem_en     = 1'b1;
                            mem_addr   = r_pix_addr;
                            n_rd_ok    = r_full || (r_pix_addr < r_wpos);
                            n_pix_addr = scpf_pkg::pos_inc(r_pix_addr);
                            n_state    = S_P1;
                        end else begin
                            n_state = S_HOLD;
                        end
                    end
                end
            end
            S_BWR: begin
                mem_en     = 1'b1;
                mem_we     = 1'b1;
                mem_addr   = r_wpos;
                mem_wdata  = r_byte;
                n_wpos     = start_pos;
                if (r_wpos == AW'(scpf_pkg::PKT - 1)) begin
                    n_full = 1'b1;
                end
                n_prev1    = r_byte;
                n_prev2    = r_prev1;
                n_sum      = sum_a;
                n_next_old = rd_byte;
                if (match) begin
                    // Latch the frame: the sync byte is cleared in the ring,
                    // which only the cached oldest byte can still observe.
                    n_next_old   = 8'h00;
                    n_sum        = sum_a - {8'h00, r_sync};
                    n_pending    = 1'b1;
                    n_pix_pos    = '0;
                    n_pix_addr   = scpf_pkg::pos_inc(start_pos);
                    fin.frame_ok = 1'b1;
                end
                if (out_free) begin
                    n_out       = fin;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_res   = fin;
                    n_state = S_HOLD;
                end
            end
            S_P1: begin
                mem_en     = 1'b1;
                mem_addr   = r_pix_addr;
                n_rd_ok    = r_full || (r_pix_addr < r_wpos);
                n_pix_addr = scpf_pkg::pos_inc(r_pix_addr);
                n_red      = rd_byte;
                n_state    = S_P2;
            end
            S_P2: begin
                mem_en     = 1'b1;
                mem_addr   = r_pix_addr;
                n_rd_ok    = r_full || (r_pix_addr < r_wpos);
                n_pix_addr = scpf_pkg::pos_inc(r_pix_addr);
                n_green    = rd_byte;
                n_state    = S_P3;
            end
            S_P3: begin
                fin.pixel_valid = 1'b1;
                fin.red         = r_red;
                fin.green       = r_green;
                fin.blue        = rd_byte;
                fin.last_pixel  = last;
                if (last) begin
                    n_pending = 1'b0;
                    n_pix_pos = '0;
                end else begin
                    n_pix_pos = r_pix_pos + PIX_W'(1);
                end
                if (out_free) begin
                    n_out       = fin;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_res   = fin;
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sync      <= scpf_pkg::SYNC_RESET;
            r_wpos      <= '0;
            r_full      <= 1'b0;
            r_sum       <= '0;
            r_pending   <= 1'b0;
            r_pix_pos   <= '0;
            r_pix_addr  <= '0;
            r_next_old  <= '0;
            r_prev1     <= '0;
            r_prev2     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sync      <= n_sync;
            r_wpos      <= n_wpos;
            r_full      <= n_full;
            r_sum       <= n_sum;
            r_pending   <= n_pending;
            r_pix_pos   <= n_pix_pos;
            r_pix_addr  <= n_pix_addr;
            r_next_old  <= n_next_old;
            r_prev1     <= n_prev1;
            r_prev2     <= n_prev2;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_rd_ok <= n_rd_ok;
        r_red   <= n_red;
        r_green <= n_green;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // The ring is never written while a latched frame is being read out.
    a_no_write_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_en && mem_we) |-> !r_pending)
        else $error("ring written during pending readout");

    // Pixel index stays inside the strip.
    a_pix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pix_pos <= PIX_W'(scpf_pkg::LED_COUNT - 1))
        else $error("pixel index out of range");

    // Write position stays inside the ring.
    a_wpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpos <= AW'(scpf_pkg::PKT - 1))
        else $error("write position out of range");

    // Once the ring has wrapped it stays full.
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_full))
        else $error("full flag dropped");

    // A latched frame always leaves a readout pending.
    a_latch_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BWR && match) |=> r_pending)
        else $error("frame latched without pending readout");

endmodule

FILE: tb/sv/scpf_framer_checker.sv
// Scoreboard for the sync/checksum pixel framer: watches the input, result and
// configuration ports, predicts every result beat and compares it field by field.
// Depends on scpf_pkg for the beat types and the window size.
module scpf_framer_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [7:0]      i_cfg_wdata,
    input  logic            i_in_valid,
    input  logic            i_in_ready,
    input  scpf_pkg::t_in   i_in_beat,
    input  logic            i_out_valid,
    input  logic            i_out_ready,
    input  scpf_pkg::t_out  i_out_beat,
    input  logic            i_final_check,
    output int              o_outstanding,
    output int              o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 40;

    // Shadow of the framer state.
    logic [7:0]  ring_img [scpf_pkg::PKT];
    int          wr_at;
    logic [15:0] run_sum;
    int          frame_at;
    bit          frame_held;
    int          pixel_no;
    logic [7:0]  sync_byte;

    scpf_pkg::t_out results_due [$];
    int             results_seen;

    initial begin
        o_outstanding = 0;
        o_mismatches  = 0;
        results_seen  = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        o_mismatches++;
        if (o_mismatches <= MAX_REPORTS) begin
            $display("[%0t] framer result %0d: %s is %0h, predicted %0h",
                     $realtime, results_seen, what, got, want);
        end
    endtask

    task automatic clear_shadow();
        int i;
        for (i = 0; i < scpf_pkg::PKT; i++) begin
            ring_img[i] = 8'h00;
        end
        wr_at      = 0;
        run_sum    = 16'h0000;
        frame_at   = 0;
        frame_held = 1'b0;
        pixel_no   = 0;
        sync_byte  = scpf_pkg::SYNC_RESET;
        results_due.delete();
    endtask

    // Applies one input beat to the shadow state and returns the result beat it causes.
    function automatic scpf_pkg::t_out frame_step(input scpf_pkg::t_in beat);
        scpf_pkg::t_out r;
        int             p;
        int             start;
        int             idx;
        logic [15:0]    check;
        r = '0;
        if (beat.func == scpf_pkg::FUNC_BYTE) begin
            if (frame_held) begin
                r.byte_dropped = 1'b1;
                return r;
            end
            p = wr_at;
            // The oldest byte leaves the sum and the byte two places back enters it.
            run_sum = run_sum - {8'h00, ring_img[p]}
                      + {8'h00, ring_img[(p + scpf_pkg::PKT - 2) % scpf_pkg::PKT]};
            ring_img[p] = beat.rx_byte;
            start = (p + 1) % scpf_pkg::PKT;
            wr_at = start;
            check = {ring_img[(p + scpf_pkg::PKT - 1) % scpf_pkg::PKT], ring_img[p]};
            if (ring_img[start] == sync_byte && check == run_sum) begin
                ring_img[start] = 8'h00;
                run_sum    = run_sum - {8'h00, sync_byte};
                frame_at   = start;
                frame_held = 1'b1;
                pixel_no   = 0;
                r.frame_ok = 1'b1;
            end
        end else if (frame_held) begin
            idx = (frame_at + 1 + 3 * pixel_no) % scpf_pkg::PKT;
            r.pixel_valid = 1'b1;
            r.red   = ring_img[idx];
            r.green = ring_img[(idx + 1) % scpf_pkg::PKT];
            r.blue  = ring_img[(idx + 2) % scpf_pkg::PKT];
            if (pixel_no + 1 >= scpf_pkg::LED_COUNT) begin
                r.last_pixel = 1'b1;
                frame_held   = 1'b0;
                pixel_no     = 0;
            end else begin
                pixel_no++;
            end
        end
        return r;
    endfunction

    task automatic compare_result(input scpf_pkg::t_out got);
        scpf_pkg::t_out want;
        results_seen++;
        if (results_due.size() == 0) begin
            report_mismatch("unrequested result beat", 1, 0);
            return;
        end
        want = results_due.pop_front();
        if (got.frame_ok !== want.frame_ok)
            report_mismatch("frame_ok", 32'(got.frame_ok), 32'(want.frame_ok));
        if (got.byte_dropped !== want.byte_dropped)
            report_mismatch("byte_dropped", 32'(got.byte_dropped), 32'(want.byte_dropped));
        if (got.pixel_valid !== want.pixel_valid)
            report_mismatch("pixel_valid", 32'(got.pixel_valid), 32'(want.pixel_valid));
        if (got.red !== want.red)
            report_mismatch("red", 32'(got.red), 32'(want.red));
        if (got.green !== want.green)
            report_mismatch("green", 32'(got.green), 32'(want.green));
        if (got.blue !== want.blue)
            report_mismatch("blue", 32'(got.blue), 32'(want.blue));
        if (got.last_pixel !== want.last_pixel)
            report_mismatch("last_pixel", 32'(got.last_pixel), 32'(want.last_pixel));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_shadow();
        end else begin
            if (i_cfg_we) begin
                sync_byte = i_cfg_wdata;
            end
            // The result leaving now always belongs to an older beat than one
            // entering at the same edge, so compare first.
            if (i_out_valid && i_out_ready) begin
                compare_result(i_out_beat);
            end
            if (i_in_valid && i_in_ready) begin
                results_due.push_back(frame_step(i_in_beat));
            end
            if (i_final_check && results_due.size() != 0) begin
                report_mismatch("results never delivered", 0, results_due.size());
                results_due.delete();
            end
        end
        o_outstanding = results_due.size();
    end

endmodule

FILE: tb/sv/tb.sv
// Top of the framer testbench: clock, reset, stimulus, result back-pressure and
// the verdict. Depends on scpf_pkg, scpf_if, the framer RTL and scpf_framer_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Receiver hold-off used once to fill the block and stall its input.
    localparam int LONG_HOLD = 300;
    localparam int FRAMES    = 4;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    logic       final_check;
    int         outstanding;
    int         mismatches;

    // Set by the stimulus when the long receiver hold-off should start.
    bit         long_hold_req;
    // While set, the sender offers beats back to back.
    bit         steady_send;

    // Every byte that the stimulus expects to reach the ring, in order. Index i
    // of this log lands in ring slot i modulo the window length, which is what
    // lets frames be planned to overlap earlier ones.
    logic [7:0] ring_log [$];

    scpf_in_if  in_ch ();
    scpf_out_if out_ch ();

    sync_checksum_pixel_framer u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    scpf_framer_checker u_chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_ch.valid),
        .i_in_ready    (in_ch.ready),
        .i_in_beat     (in_ch.data),
        .i_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .i_out_beat    (out_ch.data),
        .i_final_check (final_check),
        .o_outstanding (outstanding),
        .o_mismatches  (mismatches)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Safety net: a hung handshake ends the run here.
    initial begin
        #12_000_000;
        $display("simulation failed");
        $finish;
    end

    // Idle gap before the next input beat. Most gaps are short; a few are long
    // enough to let the block drain completely.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_send) begin
            return 0;
        end
        if (roll < 55) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Pixel content: mostly random, with the extremes and the current sync
    // value mixed in so that windows whose oldest byte looks like a sync byte
    // but whose sum is wrong come by often.
    function automatic logic [7:0] pick_pixel_byte(input logic [7:0] own_sync);
        int roll;
        roll = $urandom_range(0, 15);
        if (roll == 0) begin
            return 8'h00;
        end
        if (roll == 1) begin
            return 8'hFF;
        end
        if (roll == 2) begin
            return own_sync;
        end
        return 8'($urandom);
    endfunction

    // Offers one beat and returns at the falling edge after it was taken. On
    // entry the time is a falling edge, so valid is assigned once per step.
    task automatic send_beat(input logic func, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.data.func    <= func;
        in_ch.data.rx_byte <= b;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // A byte that the block will store, so it goes into the log too.
    task automatic send_byte(input logic [7:0] b);
        send_beat(scpf_pkg::FUNC_BYTE, b);
        ring_log.push_back(b);
    endtask

    // Drops valid and waits until every result beat has come back.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic set_sync(input logic [7:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Sends bytes until the window that starts at log index start_at is
    // complete, closing it with its big-endian sum. The sync byte of the next
    // frame is planted at next_at on the way if that slot is still ahead. With
    // spoil set one bit of the sum is flipped, so the window must not match.
    task automatic send_frame(input int start_at, input logic [7:0] own_sync,
                              input int next_at, input logic [7:0] next_sync,
                              input bit spoil);
        logic [15:0] csum;
        logic [7:0]  b;
        int          i;
        while (ring_log.size() < start_at + scpf_pkg::PKT - 2) begin
            // A pull now finds nothing latched.
            if ($urandom_range(0, 15) == 0) begin
                send_beat(scpf_pkg::FUNC_PULL, 8'($urandom));
            end
            if (ring_log.size() == start_at) begin
                b = own_sync;
            end else if (ring_log.size() == next_at) begin
                b = next_sync;
            end else begin
                b = pick_pixel_byte(own_sync);
            end
            send_byte(b);
        end
        csum = 16'h0000;
        for (i = start_at; i < start_at + scpf_pkg::PKT - 2; i++) begin
            csum += {8'h00, ring_log[i]};
        end
        if (spoil) begin
            csum ^= 16'h0001 << $urandom_range(0, 15);
        end
        send_byte(csum[15:8]);
        send_byte(csum[7:0]);
    endtask

    // Reads the latched frame out, with received bytes thrown in now and then;
    // those arrive while the readout is pending and must be dropped, so they
    // stay out of the log.
    task automatic pull_frame();
        int n;
        for (n = 0; n < scpf_pkg::LED_COUNT; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_beat(scpf_pkg::FUNC_BYTE, 8'($urandom));
            end
            send_beat(scpf_pkg::FUNC_PULL, 8'($urandom));
        end
    endtask

    // Result-side back-pressure. It mixes single-cycle stalls, longer stalls
    // and long stretches of steady ready, and serves the one long hold-off
    // that the stimulus asks for.
    initial begin : result_ready
        int stall_left;
        int steady_left;
        int roll;
        bit hold_served;
        stall_left   = 0;
        steady_left  = 0;
        hold_served  = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold_req && !hold_served) begin
                hold_served = 1'b1;
                stall_left  = LONG_HOLD;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (steady_left > 0) begin
                    steady_left--;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 50) begin
                        steady_left = $urandom_range(0, 3);
                    end else if (roll < 80) begin
                        stall_left = $urandom_range(1, 3);
                    end else if (roll < 93) begin
                        stall_left = $urandom_range(4, 12);
                    end else if (roll < 97) begin
                        stall_left = $urandom_range(25, 70);
                    end else begin
                        steady_left = $urandom_range(100, 250);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        logic [7:0] syncs [FRAMES];
        logic [7:0] next_sync;
        int         st;
        int         nx;
        int         lo;
        int         hi;
        int         roll;
        int         f;
        int         n;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 8'h00;
        final_check   = 1'b0;
        long_hold_req = 1'b0;
        steady_send   = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // With a sync value of zero the cleared ring is itself a valid frame,
        // so the very first byte, a zero, must complete one.
        set_sync(8'h00);
        send_byte(8'h00);
        // Bytes while that frame is latched are dropped; pulls walk its pixels
        // through to the last one.
        send_beat(scpf_pkg::FUNC_BYTE, 8'hFF);
        send_beat(scpf_pkg::FUNC_PULL, 8'h00);
        send_beat(scpf_pkg::FUNC_BYTE, 8'h5A);
        for (n = 1; n < scpf_pkg::LED_COUNT; n++) begin
            send_beat(scpf_pkg::FUNC_PULL, 8'hFF);
        end
        // The readout is over: pulls find nothing latched.
        send_beat(scpf_pkg::FUNC_PULL, 8'hFF);
        send_beat(scpf_pkg::FUNC_PULL, 8'h00);

        // Back to the reset sync value. A received sync byte that does not
        // close a valid window simply stays in the ring.
        set_sync(scpf_pkg::SYNC_RESET);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hFE);
        send_byte(8'h55);
        send_beat(scpf_pkg::FUNC_PULL, 8'hA5);

        // Frames with random content. Each frame after the first starts inside
        // the one before it (or, now and then, after it), so the window slides
        // to many ring offsets and the running sum crosses the ring wrap often.
        // The third frame has a broken sum and must not match.
        syncs[0] = scpf_pkg::SYNC_RESET;
        syncs[1] = 8'h00;
        syncs[2] = 8'hFF;
        syncs[3] = 8'hFF;
        st = ring_log.size();
        for (f = 0; f < FRAMES; f++) begin
            steady_send = ($urandom_range(0, 3) == 0);
            lo   = (ring_log.size() > st) ? ring_log.size() : st + 1;
            hi   = st + scpf_pkg::PKT - 3;
            roll = $urandom_range(0, 9);
            if (lo > hi || roll == 0) begin
                nx = st + scpf_pkg::PKT + $urandom_range(0, 20);
            end else if (roll < 8) begin
                nx = $urandom_range(lo, (lo + 30 < hi) ? lo + 30 : hi);
            end else begin
                nx = $urandom_range(lo, hi);
            end
            next_sync = (f + 1 < FRAMES) ? syncs[f + 1] : 8'($urandom);
            send_frame(st, syncs[f], nx, next_sync, f == 2);
            if (f != 2) begin
                // During the first readout the receiver stops for a long time
                // while pulls keep coming, so the block backs up to its input.
                if (f == 0) begin
                    long_hold_req = 1'b1;
                end
                pull_frame();
            end
            send_beat(scpf_pkg::FUNC_PULL, 8'($urandom));
            if (f + 1 < FRAMES) begin
                set_sync(syncs[f + 1]);
            end
            st = nx;
        end

        // Loose traffic under a random sync value.
        steady_send = 1'b0;
        set_sync(8'($urandom_range(1, 254)));
        repeat (60) begin
            if ($urandom_range(0, 2) == 0) begin
                send_beat(scpf_pkg::FUNC_PULL, 8'($urandom));
            end else begin
                send_byte(8'($urandom));
            end
        end

        // Drain, then give a stray late result time to show up.
        wait_idle();
        repeat (20) @(negedge clk);
        final_check <= 1'b1;
        @(negedge clk);
        final_check <= 1'b0;
        @(negedge clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
